// File: hw/rtl/scl_pkg.sv
package scl_pkg;

  localparam int unsigned PosW  = 24;
  localparam int unsigned ViewW = 23;
  localparam int unsigned GainW = 16;
  localparam int unsigned TimeW = 16;
  localparam int unsigned IdxW  = 3;

  localparam logic signed [PosW-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [PosW-1:0] POS_MIN = 24'sh800000;

  localparam logic [ViewW-1:0] VIEW_W_RESET = 23'd81920;
  localparam logic [ViewW-1:0] VIEW_H_RESET = 23'd46080;
  localparam logic [GainW-1:0] GAIN_RESET   = 16'd1280;

  // squared distance below one pixel, Q.16
  localparam logic [49:0] SNAP_SQ = 50'd65536;

  typedef enum logic [1:0] {
    ACT_FOLLOW = 2'd0,
    ACT_MOVE   = 2'd1,
    ACT_SET    = 2'd2
  } action_t;

  typedef enum logic [IdxW-1:0] {
    REG_VIEW_W   = 3'd0,
    REG_VIEW_H   = 3'd1,
    REG_BOUNDS_EN = 3'd2,
    REG_LEFT     = 3'd3,
    REG_TOP      = 3'd4,
    REG_WIDTH    = 3'd5,
    REG_HEIGHT   = 3'd6,
    REG_GAIN     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [ViewW-1:0] viewport_width;
    logic [ViewW-1:0] viewport_height;
    logic             bounds_enable;
    logic [PosW-1:0]  bounds_left;
    logic [PosW-1:0]  bounds_top;
    logic [PosW-1:0]  bounds_width;
    logic [PosW-1:0]  bounds_height;
    logic [GainW-1:0] follow_gain;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE   = 3'd0,
    MUL_SQ_X   = 3'd1,
    MUL_SQ_Y   = 3'd2,
    MUL_ALPHA  = 3'd3,
    MUL_STEP_X = 3'd4,
    MUL_STEP_Y = 3'd5
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    prep;
    logic    diff;
    mul_op_t mul_op;
    logic    acc_x;
    logic    acc_y;
    logic    round_x;
    logic    round_y;
    logic    snap;
    logic    apply;
    logic    clamp;
  } cmd_t;

  typedef struct packed {
    logic follow;
    logic snap;
  } status_t;

endpackage

// File: hw/rtl/scl_if.sv
interface scl_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [23:0] value_x;
  logic signed [23:0] value_y;
  logic [15:0]        frame_time;
  logic               target_valid;

  modport source (output valid, action, value_x, value_y, frame_time, target_valid,
                  input ready);
  modport sink (input valid, action, value_x, value_y, frame_time, target_valid,
                output ready);
endinterface

interface scl_result_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;

  modport source (output valid, pos_x, pos_y, input ready);
  modport sink (input valid, pos_x, pos_y, output ready);
endinterface

interface scl_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/scl_regs.sv
module scl_regs (
  input  logic         clk,
  input  logic         rst,
  scl_cfg_if.sink      cfg,
  output scl_pkg::cfg_t regs
);
  import scl_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.viewport_width  <= VIEW_W_RESET;
      regs.viewport_height <= VIEW_H_RESET;
      regs.bounds_enable   <= 1'b0;
      regs.bounds_left     <= '0;
      regs.bounds_top      <= '0;
      regs.bounds_width    <= '0;
      regs.bounds_height   <= '0;
      regs.follow_gain     <= GAIN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (reg_idx_t'(cfg.index))
        REG_VIEW_W:    regs.viewport_width  <= cfg.data[ViewW-1:0];
        REG_VIEW_H:    regs.viewport_height <= cfg.data[ViewW-1:0];
        REG_BOUNDS_EN: regs.bounds_enable   <= cfg.data[0];
        REG_LEFT:      regs.bounds_left     <= cfg.data;
        REG_TOP:       regs.bounds_top      <= cfg.data;
        REG_WIDTH:     regs.bounds_width    <= cfg.data;
        REG_HEIGHT:    regs.bounds_height   <= cfg.data;
        REG_GAIN:      regs.follow_gain     <= cfg.data[GainW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/scl_datapath.sv
module scl_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  scl_pkg::cfg_t         regs,
  input  scl_pkg::cmd_t         cmd,
  output scl_pkg::status_t      status,
  input  logic [1:0]            action,
  input  logic signed [23:0]    value_x,
  input  logic signed [23:0]    value_y,
  input  logic [15:0]           frame_time,
  input  logic                  target_valid,
  output logic signed [23:0]    pos_x,
  output logic signed [23:0]    pos_y
);
  import scl_pkg::*;

  function automatic logic signed [23:0] sat_pos(input logic signed [27:0] v);
    if (v > 28'(POS_MAX)) return POS_MAX;
    else if (v < 28'(POS_MIN)) return POS_MIN;
    else return v[23:0];
  endfunction

  // whole pixel, half away from zero, back to Q16.8
  function automatic logic signed [23:0] round_pos(input logic signed [58:0] v);
    logic signed [58:0] r;
    logic signed [26:0] pix;
    r   = v + $signed({27'd0, ~v[58], {31{v[58]}}});
    pix = r[58:32];
    if (pix > 27'sd32767) return POS_MAX;
    else if (pix < -27'sd32768) return POS_MIN;
    else return {pix[15:0], 8'd0};
  endfunction

  function automatic logic signed [23:0] upper_limit(input logic [23:0] origin,
                                                     input logic [23:0] size,
                                                     input logic [22:0] view);
    logic signed [27:0] h;
    h = 28'($signed(origin)) + 28'($signed(size)) - $signed({5'd0, view});
    if (h < 28'($signed(origin))) h = 28'($signed(origin));
    return sat_pos(h);
  endfunction

  logic [1:0]          act;
  logic signed [23:0]  vx, vy;
  logic [15:0]         ft;
  logic                tv;
  logic signed [23:0]  scroll_x, scroll_y;
  logic signed [23:0]  des_x, des_y;
  logic signed [23:0]  hi_x, hi_y;
  logic signed [24:0]  dx, dy;
  logic signed [57:0]  prod;
  logic [48:0]         sq;
  logic [31:0]         alpha;
  logic signed [58:0]  vsum;
  logic signed [24:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic                clamp_en;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action;
      vx  <= value_x;
      vy  <= value_y;
      ft  <= frame_time;
      tv  <= target_valid;
    end
  end

  assign status.follow = (action_t'(act) == ACT_FOLLOW) && tv;
  assign status.snap   = ({1'b0, sq} + {1'b0, prod[48:0]}) < SNAP_SQ;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      des_x <= sat_pos(28'(vx) - $signed({6'd0, regs.viewport_width[22:1]}));
      des_y <= sat_pos(28'(vy) - $signed({6'd0, regs.viewport_height[22:1]}));
      hi_x  <= upper_limit(regs.bounds_left, regs.bounds_width, regs.viewport_width);
      hi_y  <= upper_limit(regs.bounds_top, regs.bounds_height, regs.viewport_height);
    end
    if (cmd.diff) begin
      dx <= 25'(des_x) - 25'(scroll_x);
      dy <= 25'(des_y) - 25'(scroll_y);
    end
  end

  // shared multiplier
  always_comb begin
    unique case (cmd.mul_op)
      MUL_SQ_X: begin
        mul_a = dx;
        mul_b = 33'(dx);
      end
      MUL_SQ_Y: begin
        mul_a = dy;
        mul_b = 33'(dy);
      end
      MUL_ALPHA: begin
        mul_a = $signed({9'd0, regs.follow_gain});
        mul_b = $signed({17'd0, ft});
      end
      MUL_STEP_X: begin
        mul_a = dx;
        mul_b = $signed({1'b0, prod[31:0]});
      end
      MUL_STEP_Y: begin
        mul_a = dy;
        mul_b = $signed({1'b0, alpha});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_op != MUL_NONE) prod <= mul_a * mul_b;
    if (cmd.mul_op == MUL_SQ_Y) sq <= prod[48:0];
    if (cmd.mul_op == MUL_STEP_X) alpha <= prod[31:0];
    if (cmd.acc_x) vsum <= $signed({{11{scroll_x[23]}}, scroll_x, 24'd0}) + 59'(prod);
    else if (cmd.acc_y) vsum <= $signed({{11{scroll_y[23]}}, scroll_y, 24'd0}) + 59'(prod);
  end

  assign clamp_en = regs.bounds_enable && ($signed(regs.bounds_width) > 24'sd0)
                    && ($signed(regs.bounds_height) > 24'sd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_x <= '0;
      scroll_y <= '0;
    end else begin
      if (cmd.snap) begin
        scroll_x <= des_x;
        scroll_y <= des_y;
      end
      if (cmd.round_x) scroll_x <= round_pos(vsum);
      if (cmd.round_y) scroll_y <= round_pos(vsum);
      if (cmd.apply) begin
        unique case (action_t'(act))
          ACT_MOVE: begin
            scroll_x <= sat_pos(28'(scroll_x) + 28'(vx));
            scroll_y <= sat_pos(28'(scroll_y) + 28'(vy));
          end
          ACT_SET: begin
            scroll_x <= vx;
            scroll_y <= vy;
          end
          default: ;
        endcase
      end
      if (cmd.clamp && clamp_en) begin
        if (scroll_x < $signed(regs.bounds_left)) scroll_x <= regs.bounds_left;
        else if (scroll_x > hi_x) scroll_x <= hi_x;
        if (scroll_y < $signed(regs.bounds_top)) scroll_y <= regs.bounds_top;
        else if (scroll_y > hi_y) scroll_y <= hi_y;
      end
    end
  end

  assign pos_x = scroll_x;
  assign pos_y = scroll_y;

endmodule

// File: hw/rtl/scl_ctrl.sv
module scl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  output logic             result_valid,
  input  logic             result_ready,
  input  scl_pkg::status_t status,
  output scl_pkg::cmd_t    cmd
);
  import scl_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_PREP   = 14'b00000000000010,
    S_DIFF   = 14'b00000000000100,
    S_SQX    = 14'b00000000001000,
    S_SQY    = 14'b00000000010000,
    S_ALPHA  = 14'b00000000100000,
    S_SNAP   = 14'b00000001000000,
    S_MULX   = 14'b00000010000000,
    S_MULY   = 14'b00000100000000,
    S_RNDX   = 14'b00001000000000,
    S_RNDY   = 14'b00010000000000,
    S_APPLY  = 14'b00100000000000,
    S_CLAMP  = 14'b01000000000000,
    S_RESULT = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  assign item_ready   = (state == S_IDLE);
  assign result_valid = (state == S_RESULT);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = item_valid;
        if (item_valid) state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = status.follow ? S_DIFF : S_APPLY;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_SQX;
      end
      S_SQX: begin
        cmd.mul_op = MUL_SQ_X;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.mul_op = MUL_SQ_Y;
        state_next = S_ALPHA;
      end
      S_ALPHA: begin
        cmd.mul_op = MUL_ALPHA;
        state_next = status.snap ? S_SNAP : S_MULX;
      end
      S_SNAP: begin
        cmd.snap   = 1'b1;
        state_next = S_CLAMP;
      end
      S_MULX: begin
        cmd.mul_op = MUL_STEP_X;
        state_next = S_MULY;
      end
      S_MULY: begin
        cmd.mul_op = MUL_STEP_Y;
        cmd.acc_x  = 1'b1;
        state_next = S_RNDX;
      end
      S_RNDX: begin
        cmd.round_x = 1'b1;
        cmd.acc_y   = 1'b1;
        state_next  = S_RNDY;
      end
      S_RNDY: begin
        cmd.round_y = 1'b1;
        state_next  = S_CLAMP;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (result_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/smoothed_follow_scroll_clamp.sv
// smoothed follow scroll with bounds clamp. keeps a signed Q16.8 scroll position
// and returns it once per input transaction. action 0 (follow) aims at the target
// minus half the viewport: within one pixel it snaps there, otherwise it moves
// alpha = follow_gain * frame_time times the distance and rounds each axis to a
// whole pixel, half away from zero. action 1 adds an offset with saturation,
// action 2 loads a position, action 3 and a follow without target_valid keep the
// position. after every transaction the position is clamped to the bounds
// rectangle when bounds are on and both sizes are positive. one transaction is
// worked on at a time: a follow steps through prep, diff, both squares, alpha,
// then axis steps and roundings or a snap; a move or set through prep and apply;
// all end in clamp and a result that waits for ready. the follow path uses the
// single shared 25x33 multiplier in turn for dx^2, dy^2, alpha and both axis
// steps. config writes apply at once and can reach a transaction in progress.
module smoothed_follow_scroll_clamp (
  input logic          clk,
  input logic          rst,
  scl_item_if.sink     item,
  scl_result_if.source result,
  scl_cfg_if.sink      cfg
);
  import scl_pkg::*;

  cfg_t    regs;
  cmd_t    cmd;
  status_t status;

  // configuration register file
  scl_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // sequencer: accepts a transaction, steps the datapath, presents the result
  scl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // scroll state, shared multiplier, rounding and clamp
  scl_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .regs         (regs),
    .cmd          (cmd),
    .status       (status),
    .action       (item.action),
    .value_x      (item.value_x),
    .value_y      (item.value_y),
    .frame_time   (item.frame_time),
    .target_valid (item.target_valid),
    .pos_x        (result.pos_x),
    .pos_y        (result.pos_y)
  );

endmodule
